>>> hdl/sus_pkg.sv
// Shared types and constants for the sorted unique set unit.
// Used by sus_cell, sorted_unique_set_unit and the testbench; depends on nothing else.
package sus_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned TotalWidth      = 7;

  // Operation codes carried in the opcode field.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic signed [ValueWidth-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                  found;
    logic                  dropped;
    logic [TotalWidth-1:0] entry_total;
  } res_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the broadcast key
    logic ins_en;  // open a slot at the key's sorted place and shift right
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

endpackage

>>> hdl/sus_cell.sv
// One storage cell of the sorted chain: holds a value, compares it with the key.
// Depends on sus_pkg.
module sus_cell (
  input  logic                                  clk_i,
  input  sus_pkg::cell_ctrl_t                   ctrl_i,
  input  logic                                  valid_i,
  input  logic signed [sus_pkg::ValueWidth-1:0] key_i,
  input  logic signed [sus_pkg::ValueWidth-1:0] prev_value_i,
  input  logic                                  prev_lt_i,
  output logic signed [sus_pkg::ValueWidth-1:0] value_o,
  output logic                                  lt_o,
  output logic                                  eq_o
);

  logic signed [sus_pkg::ValueWidth-1:0] value_q, value_d;
  logic                                  lt_q, lt_d;
  logic                                  eq_q, eq_d;

  always_comb begin
    lt_d    = lt_q;
    eq_d    = eq_q;
    value_d = value_q;
    if (ctrl_i.cmp_en) begin
      lt_d = valid_i && (value_q < key_i);
      eq_d = valid_i && (value_q == key_i);
    end
    // Keep a smaller value, take the key at the boundary, else shift in from the left.
    if (ctrl_i.ins_en && !lt_q) begin
      if (prev_lt_i) begin
        value_d = key_i;
      end else begin
        value_d = prev_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    lt_q    <= lt_d;
    eq_q    <= eq_d;
  end

  assign value_o = value_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

>>> hdl/sorted_unique_set_unit.sv
// Top level of the sorted unique set unit: control, entry count and cell chain.
// Depends on sus_pkg and sus_cell.
//
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order in a
// row of cells. Each item (start high while busy is low) is one operation:
// insert, search or clear; an unused opcode changes nothing. Every item gives
// exactly one result on result_o, shown for one cycle while done_o is high;
// the receiver cannot stall it, so capture it in that cycle. After acceptance
// an item passes through a step in which every cell compares its value with
// the key, a step in which the cells shift right to open the key's slot and
// the result is registered, and a step in which the result is shown; a new
// item may be accepted at the clock edge that ends that last step. For an
// insert or search, found reports the value was present before the operation;
// dropped flags a new value refused because the set is full; entry_total is
// the count after the operation, kept to its low seven bits when CAPACITY
// exceeds 127.
module sorted_unique_set_unit #(
  parameter int unsigned CAPACITY = sus_pkg::DefaultCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sus_pkg::cmd_t cmd_i,
  output logic          done_o,
  output sus_pkg::res_t result_o
);

  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);

  sus_pkg::state_e state_q, state_d;
  sus_pkg::cmd_t   cmd_q;
  logic [CntWidth-1:0] count_q, count_d;
  logic            done_q;
  sus_pkg::res_t   result_q, result_d;

  sus_pkg::cell_ctrl_t ctrl;

  logic signed [sus_pkg::ValueWidth-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_valid;

  logic accept;
  logic found;
  logic full;
  logic is_insert;
  logic is_search;

  assign accept    = start && (state_q == sus_pkg::ST_IDLE);
  assign busy      = (state_q != sus_pkg::ST_IDLE);
  assign is_insert = (cmd_q.opcode == sus_pkg::OP_INSERT);
  assign is_search = (cmd_q.opcode == sus_pkg::OP_SEARCH);
  assign full      = (count_q >= CntWidth'(CAPACITY));
  // A match can sit in at most one cell, so a wide OR is enough.
  assign found     = (is_insert || is_search) && (|cell_eq);

  // Compare in ST_CMP; shift in ST_UPD only for a new value with room left.
  always_comb begin
    ctrl.cmp_en = (state_q == sus_pkg::ST_CMP);
    ctrl.ins_en = (state_q == sus_pkg::ST_UPD) && is_insert && !found && !full;
  end

  // Sequencer: latch, compare, update.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sus_pkg::ST_IDLE: if (accept) state_d = sus_pkg::ST_CMP;
      sus_pkg::ST_CMP:  state_d = sus_pkg::ST_UPD;
      sus_pkg::ST_UPD:  state_d = sus_pkg::ST_IDLE;
      default:          state_d = sus_pkg::ST_IDLE;
    endcase
  end

  // Count update and result assembly in the last step.
  always_comb begin
    count_d  = count_q;
    result_d = result_q;
    if (state_q == sus_pkg::ST_UPD) begin
      if (ctrl.ins_en) begin
        count_d = count_q + CntWidth'(1);
      end else if (cmd_q.opcode == sus_pkg::OP_CLEAR) begin
        count_d = '0;
      end
      result_d.found       = found;
      result_d.dropped     = is_insert && !found && full;
      result_d.entry_total = sus_pkg::TotalWidth'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sus_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == sus_pkg::ST_UPD);
    end
  end

  // Payload registers: hold the command and the last result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    result_q <= result_d;
  end

  // Cell chain: a cell is live when its index lies below the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sus_pkg::ValueWidth-1:0] prev_value;
    logic                                  prev_lt;

    assign cell_valid[i] = (count_q > CntWidth'(i));

    if (i == 0) begin : g_head
      assign prev_value = cmd_q.value;
      assign prev_lt    = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    sus_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (cell_valid[i]),
      .key_i        (cmd_q.value),
      .prev_value_i (prev_value),
      .prev_lt_i    (prev_lt),
      .value_o      (cell_value[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTH
  // A result is shown only while the unit is ready for the next item.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // An accepted item always produces a result.
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("accepted item produced no result");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(CAPACITY))
    else $error("entry count above capacity");

  // A refused insert never reports the value as present.
  a_drop_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.dropped) |-> !result_o.found)
    else $error("dropped and found together");
`endif

endmodule

>>> verif/tb_sorted_unique_set_unit.sv
// Self-checking testbench for sorted_unique_set_unit: directed and random set operations
// against an in-bench model of the sorted set. Depends on sus_pkg and the RTL top level.
module tb_sorted_unique_set_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sus_pkg::*;

  localparam int unsigned Capacity   = DefaultCapacity;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;   // no-op opcode
  localparam int          RandItems  = 1400;
  localparam int          TailItems  = 150;    // last items run without gaps
  localparam int          MaxReports = 10;
  localparam int          DrainCycles = 12;

  localparam logic signed [ValueWidth-1:0] KeyMin = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam logic signed [ValueWidth-1:0] KeyMax = {1'b0, {(ValueWidth-1){1'b1}}};

  // Kinds of key pool used by a random phase.
  typedef enum int {
    POOL_NARROW,
    POOL_WIDE,
    POOL_EDGES
  } pool_e;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  logic  busy;
  cmd_t  cmd    = '0;
  logic  done;
  res_t  result;

  sorted_unique_set_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd),
    .done_o  (done),
    .result_o(result)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Set model: the stored keys in ascending signed order and their count.
  // ---------------------------------------------------------------------------
  logic signed [ValueWidth-1:0] set_keys [Capacity];
  int unsigned                  set_count = 0;

  // Apply one operation to the model and return the result it must produce.
  function automatic res_t apply_set_op(cmd_t c);
    res_t                         r;
    logic signed [ValueWidth-1:0] key;
    int unsigned                  pos;
    int unsigned                  j;
    logic                         hit;
    r   = '0;
    key = c.value;
    pos = 0;
    hit = 1'b0;
    case (c.opcode)
      OP_INSERT, OP_SEARCH: begin
        // Find the first slot whose key is not below the search key.
        while (pos < set_count && set_keys[pos] < key) pos++;
        hit     = (pos < set_count) && (set_keys[pos] == key);
        r.found = hit;
        if (c.opcode == OP_INSERT && !hit) begin
          if (set_count >= Capacity) begin
            r.dropped = 1'b1;
          end else begin
            // Open the slot by shifting the upper part of the row right.
            for (j = set_count; j > pos; j--) set_keys[j] = set_keys[j-1];
            set_keys[pos] = key;
            set_count++;
          end
        end
      end
      OP_CLEAR: begin
        set_count = 0;
      end
      default: begin
      end
    endcase
    r.entry_total = set_count[TotalWidth-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: items waiting to be driven, and results still owed by the block.
  // ---------------------------------------------------------------------------
  cmd_t pending_cmds[$];
  res_t owed_results[$];
  int   fail_count = 0;

  task automatic queue_cmd(logic [1:0] op, logic signed [ValueWidth-1:0] val);
    cmd_t c;
    c.opcode = op;
    c.value  = val;
    pending_cmds.push_back(c);
  endtask

  // Draw a key from the pool of the current phase.
  function automatic logic signed [ValueWidth-1:0] pick_key(pool_e kind, int base,
                                                           int unsigned span);
    logic signed [ValueWidth-1:0] k;
    case (kind)
      POOL_NARROW: k = base + $signed($urandom_range(0, span));
      POOL_WIDE:   k = $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0:       k = KeyMin;
          1:       k = KeyMax;
          2:       k = KeyMin + $signed($urandom_range(1, 40));
          3:       k = KeyMax - $signed($urandom_range(1, 40));
          4:       k = $signed($urandom_range(0, 40)) - 20;
          default: k = $urandom;
        endcase
      end
    endcase
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold an item on cmd with start high until the block takes it, then
  // present the next one or insert an idle burst. Predict at acceptance.
  // ---------------------------------------------------------------------------
  int   gap_left = 0;
  bit   holding  = 1'b0;
  bit   gaps_on  = 1'b1;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        owed_results.push_back(apply_set_op(cmd));
        holding = 1'b0;
        // Flip between gapped and back-to-back stretches now and then.
        if ($urandom_range(0, 59) == 0) gaps_on = !gaps_on;
      end else begin
        holding = start;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > TailItems && gaps_on &&
                     $urandom_range(0, 5) == 0) begin
          // Start an idle burst whose length is drawn at random, this cycle included.
          gap_left = $urandom_range(1, 13) - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd   <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is taken in its single cycle and checked
  // against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("tb: unexpected result found=%0b dropped=%0b total=%0d",
                   result.found, result.dropped, result.entry_total);
      end else begin
        want = owed_results.pop_front();
        if (result.found !== want.found || result.dropped !== want.dropped ||
            result.entry_total !== want.entry_total) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("tb: mismatch expected found=%0b dropped=%0b total=%0d,",
                     want.found, want.dropped, want.entry_total,
                     " got found=%0b dropped=%0b total=%0d",
                     result.found, result.dropped, result.entry_total);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the item list, release reset, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [ValueWidth-1:0] phase_keys[$];
    logic signed [ValueWidth-1:0] k;
    pool_e       kind;
    int          base;
    int unsigned span;
    int          phase_len;
    int          made;
    int unsigned roll;

    // Directed part: extremes, duplicates, misses, the unused opcode, clears.
    queue_cmd(OP_SEARCH, 32'sd0);        // search on an empty set
    queue_cmd(OP_INSERT, 32'sd0);
    queue_cmd(OP_INSERT, 32'sd0);        // insert of a key already present
    queue_cmd(OP_INSERT, KeyMin);
    queue_cmd(OP_INSERT, KeyMax);
    queue_cmd(OP_INSERT, -32'sd1);
    queue_cmd(OP_INSERT, 32'sd1);
    queue_cmd(OP_INSERT, KeyMin);        // duplicate at the low end
    queue_cmd(OP_SEARCH, KeyMin);
    queue_cmd(OP_SEARCH, KeyMax);
    queue_cmd(OP_SEARCH, -32'sd1);
    queue_cmd(OP_SEARCH, 32'sd2);        // miss between stored keys
    queue_cmd(OP_UNUSED, 32'sd5);        // no-op keeps the count
    queue_cmd(OP_SEARCH, 32'sd5);
    queue_cmd(OP_UNUSED, -32'sd1);
    queue_cmd(OP_CLEAR, 32'sd7);
    queue_cmd(OP_SEARCH, 32'sd0);        // search after clear
    queue_cmd(OP_CLEAR, -32'sd1);        // clear of an empty set
    queue_cmd(OP_INSERT, KeyMax);
    queue_cmd(OP_INSERT, KeyMax - 1);
    queue_cmd(OP_SEARCH, KeyMax - 1);

    // Random part: phases that begin with a clear and lean on inserts, so the
    // set fills up, often to capacity, and searches hit stored keys.
    made = 0;
    while (made < RandItems) begin
      kind      = pool_e'($urandom_range(0, 2));
      base      = $signed($urandom);
      span      = $urandom_range(8, 100);
      phase_len = (kind == POOL_WIDE) ? $urandom_range(100, 220) : $urandom_range(50, 160);
      phase_keys.delete();
      queue_cmd(OP_CLEAR, $urandom);
      made++;
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          k = pick_key(kind, base, span);
          // Re-insert a known key now and then.
          if (phase_keys.size() > 0 && $urandom_range(0, 7) == 0)
            k = phase_keys[$urandom_range(0, phase_keys.size() - 1)];
          phase_keys.push_back(k);
          queue_cmd(OP_INSERT, k);
        end else if (roll < 92) begin
          if (phase_keys.size() > 0 && $urandom_range(0, 1) == 0)
            k = phase_keys[$urandom_range(0, phase_keys.size() - 1)];
          else
            k = pick_key(kind, base, span);
          queue_cmd(OP_SEARCH, k);
        end else if (roll < 94) begin
          queue_cmd(OP_CLEAR, $urandom);
        end else begin
          queue_cmd(OP_UNUSED, $urandom);
        end
        made++;
      end
    end

    // Hold reset, then release it at a clock edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all items taken, all results back, then a few quiet cycles.
    wait (pending_cmds.size() == 0 && start == 1'b0);
    wait (owed_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
hdl/sus_pkg.sv
hdl/sus_cell.sv
hdl/sorted_unique_set_unit.sv
verif/tb_sorted_unique_set_unit.sv
